### rtl/core/tts_pkg.sv
// Shared types, register indexes and constants for the tilt-to-stick shaper.
// No dependencies; used by every file under rtl/core.
package tts_pkg;

  typedef struct packed {
    logic               act;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } item_t;

  typedef struct packed {
    logic        tilt_enable;
    logic [14:0] pitch_full_angle;
    logic [14:0] roll_full_angle;
    logic [13:0] dead_zone;
    logic [14:0] expo_weight;
    logic [14:0] smoothing;
  } cfg_t;

  localparam logic [2:0] REG_TILT_ENABLE = 3'd0;
  localparam logic [2:0] REG_PITCH_FULL  = 3'd1;
  localparam logic [2:0] REG_ROLL_FULL   = 3'd2;
  localparam logic [2:0] REG_DEAD_ZONE   = 3'd3;
  localparam logic [2:0] REG_EXPO_WEIGHT = 3'd4;
  localparam logic [2:0] REG_SMOOTHING   = 3'd5;

  localparam logic [14:0] RST_PITCH_FULL  = 15'd2574;
  localparam logic [14:0] RST_ROLL_FULL   = 15'd5004;
  localparam logic [13:0] RST_DEAD_ZONE   = 14'd492;
  localparam logic [14:0] RST_EXPO_WEIGHT = 15'd5734;
  localparam logic [14:0] RST_SMOOTHING   = 15'd4096;

  localparam logic signed [28:0] PI_Q24  = 29'sd52707179;
  localparam logic signed [28:0] PI_Q13  = 29'sd25736;
  localparam logic [14:0]        Q14_ONE = 15'd16384;
  localparam logic signed [17:0] Q16_ONE = 18'sd65536;

  function automatic logic [23:0] atan_entry(input logic [4:0] i);
    logic [23:0] r;
    unique case (i)
      5'd0:  r = 24'd13176795;
      5'd1:  r = 24'd7778716;
      5'd2:  r = 24'd4110060;
      5'd3:  r = 24'd2086331;
      5'd4:  r = 24'd1047214;
      5'd5:  r = 24'd524117;
      5'd6:  r = 24'd262123;
      5'd7:  r = 24'd131069;
      5'd8:  r = 24'd65536;
      5'd9:  r = 24'd32768;
      5'd10: r = 24'd16384;
      5'd11: r = 24'd8192;
      5'd12: r = 24'd4096;
      5'd13: r = 24'd2048;
      5'd14: r = 24'd1024;
      5'd15: r = 24'd512;
      5'd16: r = 24'd256;
      5'd17: r = 24'd128;
      5'd18: r = 24'd64;
      5'd19: r = 24'd32;
      5'd20: r = 24'd16;
      5'd21: r = 24'd8;
      5'd22: r = 24'd4;
      5'd23: r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/tts_front.sv
// Input side: accepts sample transactions and holds them in a two-entry queue.
// Depends on tts_pkg for the item type.
module tts_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [47:0]     s_tdata,  // accel_x, accel_y, accel_z
  input  logic            s_tuser,  // action
  output logic            q_valid,
  output tts_pkg::item_t  q_item,
  input  logic            q_pop
);

  tts_pkg::item_t slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= '{act: s_tuser, ax: $signed(s_tdata[15:0]),
                    ay: $signed(s_tdata[31:16]), az: $signed(s_tdata[47:32])};
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### rtl/core/tts_back.sv
// Processing side: square root, CORDIC angles, shared divider, expo and low-pass.
// Depends on tts_pkg; takes items from tts_front and drives the result register.
module tts_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  tts_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  tts_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [31:0]     m_tdata,  // aileron, elevator
  output logic            m_tuser   // updated
);

  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SQRT    = 5'd1;
  localparam logic [4:0] S_CINIT   = 5'd2;
  localparam logic [4:0] S_CORD    = 5'd3;
  localparam logic [4:0] S_CEND    = 5'd4;
  localparam logic [4:0] S_DECIDE  = 5'd5;
  localparam logic [4:0] S_DEFINIT = 5'd6;
  localparam logic [4:0] S_DIV     = 5'd7;
  localparam logic [4:0] S_DEFEND  = 5'd8;
  localparam logic [4:0] S_LINEND  = 5'd9;
  localparam logic [4:0] S_SQ      = 5'd10;
  localparam logic [4:0] S_CUBE    = 5'd11;
  localparam logic [4:0] S_MIX1    = 5'd12;
  localparam logic [4:0] S_MIX2    = 5'd13;
  localparam logic [4:0] S_LP1     = 5'd14;
  localparam logic [4:0] S_LP2     = 5'd15;
  localparam logic [4:0] S_OUT     = 5'd16;

  logic [4:0]          state;
  tts_pkg::item_t      cur;
  logic                upd;

  logic [31:0]         sq_n;
  logic [31:0]         sq_root;
  logic [31:0]         sq_bit;
  logic [3:0]          sq_cnt;

  logic                csel;
  logic signed [35:0]  cx;
  logic signed [35:0]  cy;
  logic signed [28:0]  cacc;
  logic [SW-1:0]       ccnt;
  logic signed [15:0]  pa;
  logic signed [15:0]  ra;

  logic signed [15:0]  ref_pitch;
  logic signed [15:0]  ref_roll;
  logic                have_ref;
  logic signed [17:0]  aileron_filter;
  logic signed [17:0]  elevator_filter;

  logic [30:0]         dv_q;
  logic [14:0]         dv_r;
  logic [14:0]         dv_d;
  logic [4:0]          dv_cnt;
  logic [4:0]          dv_ret;

  logic                axis;
  logic                sgn;
  logic [14:0]         lin;
  logic [28:0]         sqp;
  logic [14:0]         cub;
  logic [29:0]         mixt;
  logic [14:0]         res;
  logic signed [33:0]  lpm;

  // combinational helpers
  logic [31:0]         sq_try;
  logic signed [17:0]  cnum;
  logic signed [17:0]  cden;
  logic signed [28:0]  catan;
  logic signed [28:0]  cround;
  logic signed [15:0]  cang;
  logic signed [16:0]  diff;
  logic [15:0]         dmag;
  logic [14:0]         full;
  logic [15:0]         dv_rs;
  logic                dv_ge;
  logic [14:0]         defq;
  logic [14:0]         one_dz;
  logic [14:0]         wt;
  logic [14:0]         alpha;
  logic [43:0]         cube_p;
  logic [30:0]         mix_sum;
  logic signed [17:0]  filt_old;
  logic signed [17:0]  x16;
  logic signed [33:0]  lp_acc;
  logic signed [19:0]  lp_r;
  logic signed [17:0]  lp_new;
  logic signed [17:0]  ai_r;
  logic signed [17:0]  el_r;

  assign q_pop  = (state == S_IDLE) && q_valid;
  assign sq_try = sq_root + sq_bit;

  always_comb begin
    if (csel) begin
      cnum = 18'(cur.ay);
      cden = $signed({1'b0, sq_root[16:0]});
    end else begin
      cnum = 18'(cur.ax);
      cden = 18'(cur.az);
    end
    catan  = $signed({5'd0, tts_pkg::atan_entry(5'(ccnt))});
    cround = (cacc + 29'sd1024) >>> 11;
    if (cround > tts_pkg::PI_Q13) cang = 16'(tts_pkg::PI_Q13);
    else if (cround < -tts_pkg::PI_Q13) cang = 16'(-tts_pkg::PI_Q13);
    else cang = cround[15:0];

    diff  = axis ? (17'(pa) - 17'(ref_pitch)) : (17'(ra) - 17'(ref_roll));
    dmag  = diff[16] ? 16'(-diff) : diff[15:0];
    full  = axis ? cfg.pitch_full_angle : cfg.roll_full_angle;
    if (full == 15'd0) full = 15'd1;

    dv_rs = {dv_r, dv_q[30]};
    dv_ge = dv_rs >= {1'b0, dv_d};
    defq  = (dv_q > 31'(tts_pkg::Q14_ONE)) ? tts_pkg::Q14_ONE : dv_q[14:0];
    one_dz = tts_pkg::Q14_ONE - {1'b0, cfg.dead_zone};
    wt    = (cfg.expo_weight > tts_pkg::Q14_ONE) ? tts_pkg::Q14_ONE : cfg.expo_weight;
    alpha = (cfg.smoothing > tts_pkg::Q14_ONE) ? tts_pkg::Q14_ONE : cfg.smoothing;

    cube_p  = 44'(sqp) * 44'(lin);
    mix_sum = 31'(mixt) + 31'(30'(tts_pkg::Q14_ONE - wt) * 30'(lin)) + 31'd8192;

    filt_old = axis ? elevator_filter : aileron_filter;
    x16      = sgn ? -$signed({1'b0, res, 2'b00}) : $signed({1'b0, res, 2'b00});
    lp_acc   = lpm + 34'(x16) * 34'($signed({1'b0, alpha}));
    lp_r     = 20'((lp_acc + 34'sd8192) >>> 14);
    if (lp_r > 20'(tts_pkg::Q16_ONE)) lp_new = tts_pkg::Q16_ONE;
    else if (lp_r < -20'(tts_pkg::Q16_ONE)) lp_new = -tts_pkg::Q16_ONE;
    else lp_new = lp_r[17:0];

    ai_r = (aileron_filter + 18'sd2) >>> 2;
    el_r = (elevator_filter + 18'sd2) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      have_ref        <= 1'b0;
      ref_pitch       <= '0;
      ref_roll        <= '0;
      aileron_filter  <= '0;
      elevator_filter <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur     <= q_item;
            sq_n    <= 32'(33'(q_item.ax * q_item.ax) + 33'(q_item.az * q_item.az));
            sq_root <= '0;
            sq_bit  <= 32'h4000_0000;
            sq_cnt  <= '0;
            upd     <= 1'b0;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_n >= sq_try) begin
            sq_n    <= sq_n - sq_try;
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 4'd1;
          if (sq_cnt == 4'd15) begin
            csel  <= 1'b0;
            state <= S_CINIT;
          end
        end
        S_CINIT: begin
          ccnt <= '0;
          if (cnum == 18'sd0 && cden == 18'sd0) begin
            cacc  <= '0;
            state <= S_CEND;
          end else begin
            if (cden < 0) begin
              cacc <= (cnum >= 0) ? tts_pkg::PI_Q24 : -tts_pkg::PI_Q24;
              cx   <= 36'(-cden) <<< 14;
              cy   <= 36'(-cnum) <<< 14;
            end else begin
              cacc <= '0;
              cx   <= 36'(cden) <<< 14;
              cy   <= 36'(cnum) <<< 14;
            end
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (cy > 0) begin
            cx   <= cx + (cy >>> ccnt);
            cy   <= cy - (cx >>> ccnt);
            cacc <= cacc + catan;
          end else begin
            cx   <= cx - (cy >>> ccnt);
            cy   <= cy + (cx >>> ccnt);
            cacc <= cacc - catan;
          end
          ccnt <= ccnt + SW'(1);
          if (ccnt == SW'(CORDIC_STEPS - 1)) state <= S_CEND;
        end
        S_CEND: begin
          if (csel) begin
            ra    <= cang;
            state <= S_DECIDE;
          end else begin
            pa    <= cang;
            csel  <= 1'b1;
            state <= S_CINIT;
          end
        end
        S_DECIDE: begin
          if (cur.act || (cfg.tilt_enable && !have_ref)) begin
            ref_pitch <= pa;
            ref_roll  <= ra;
            have_ref  <= 1'b1;
            state     <= S_OUT;
          end else if (!cfg.tilt_enable) begin
            aileron_filter  <= '0;
            elevator_filter <= '0;
            state           <= S_OUT;
          end else begin
            axis  <= 1'b0;
            state <= S_DEFINIT;
          end
        end
        S_DEFINIT: begin
          sgn    <= diff[16] ^ axis;
          dv_q   <= 31'({dmag, 14'd0}) + 31'(full >> 1);
          dv_r   <= '0;
          dv_d   <= full;
          dv_cnt <= '0;
          dv_ret <= S_DEFEND;
          state  <= S_DIV;
        end
        S_DIV: begin
          dv_r   <= dv_ge ? 15'(dv_rs - {1'b0, dv_d}) : dv_rs[14:0];
          dv_q   <= {dv_q[29:0], dv_ge};
          dv_cnt <= dv_cnt + 5'd1;
          if (dv_cnt == 5'd30) state <= dv_ret;
        end
        S_DEFEND: begin
          if (defq < {1'b0, cfg.dead_zone}) begin
            res   <= '0;
            state <= S_LP1;
          end else begin
            dv_q   <= 31'({15'(defq - {1'b0, cfg.dead_zone}), 14'd0}) + 31'(one_dz >> 1);
            dv_r   <= '0;
            dv_d   <= one_dz;
            dv_cnt <= '0;
            dv_ret <= S_LINEND;
            state  <= S_DIV;
          end
        end
        S_LINEND: begin
          lin   <= defq;
          state <= S_SQ;
        end
        S_SQ: begin
          sqp   <= 29'(30'(lin) * 30'(lin));
          state <= S_CUBE;
        end
        S_CUBE: begin
          cub   <= 15'((cube_p + 44'd134217728) >> 28);
          state <= S_MIX1;
        end
        S_MIX1: begin
          mixt  <= 30'(wt) * 30'(cub);
          state <= S_MIX2;
        end
        S_MIX2: begin
          res   <= 15'(mix_sum >> 14);
          state <= S_LP1;
        end
        S_LP1: begin
          lpm   <= 34'(filt_old) * 34'($signed({1'b0, 15'(tts_pkg::Q14_ONE - alpha)}));
          state <= S_LP2;
        end
        S_LP2: begin
          if (axis) begin
            elevator_filter <= lp_new;
            upd             <= 1'b1;
            state           <= S_OUT;
          end else begin
            aileron_filter <= lp_new;
            axis           <= 1'b1;
            state          <= S_DEFINIT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {el_r[15:0], ai_r[15:0]};
            m_tuser  <= upd;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_filt_range: assert property (@(posedge clk) disable iff (rst)
    aileron_filter <= tts_pkg::Q16_ONE && aileron_filter >= -tts_pkg::Q16_ONE &&
    elevator_filter <= tts_pkg::Q16_ONE && elevator_filter >= -tts_pkg::Q16_ONE)
    else $error("filter state out of range");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dv_d != 15'd0)
    else $error("divide by zero");
  a_ref_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(have_ref) |-> $past(state) == S_DECIDE)
    else $error("reference set outside decision");
  a_upd_needs_ref: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> have_ref)
    else $error("update without reference");
`endif

endmodule

### rtl/core/tilt_to_stick_shaper.sv
// Top level of the tilt-to-stick shaper: configuration registers, front queue
// and processing back end. Depends on tts_pkg, tts_front and tts_back.
//
// Usage: s_tdata carries accel_x, accel_y, accel_z; s_tuser carries the action
// (0 process, 1 calibrate). Each accepted transaction yields exactly one result
// on m_tdata (aileron, elevator in Q1.14) with m_tuser = updated.
// Configuration is written through cfg_wen/cfg_index/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this. Each item
// passes through the 16-step square root and the CORDIC pitch and roll passes; a
// processed sample also takes up to four 31-step divisions on the shared divider.
// The back end finishes one item before it takes the next; a two-entry queue
// takes input while the back end works.
// Reset clears the queue, the result valid flag, the reference and both filters
// and loads the default configuration. If the receiver stalls, the result is
// held in the output register and the back end waits; the queue keeps
// accepting until full.
module tilt_to_stick_shaper #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // accel_x, accel_y, accel_z
  input  logic        s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // aileron, elevator
  output logic        m_tuser,  // updated
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);

  tts_pkg::cfg_t  cfg;
  tts_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tilt_enable      <= 1'b1;
      cfg.pitch_full_angle <= tts_pkg::RST_PITCH_FULL;
      cfg.roll_full_angle  <= tts_pkg::RST_ROLL_FULL;
      cfg.dead_zone        <= tts_pkg::RST_DEAD_ZONE;
      cfg.expo_weight      <= tts_pkg::RST_EXPO_WEIGHT;
      cfg.smoothing        <= tts_pkg::RST_SMOOTHING;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        tts_pkg::REG_TILT_ENABLE: cfg.tilt_enable      <= cfg_wdata[0];
        tts_pkg::REG_PITCH_FULL:  cfg.pitch_full_angle <= cfg_wdata;
        tts_pkg::REG_ROLL_FULL:   cfg.roll_full_angle  <= cfg_wdata;
        tts_pkg::REG_DEAD_ZONE:   cfg.dead_zone        <= cfg_wdata[13:0];
        tts_pkg::REG_EXPO_WEIGHT: cfg.expo_weight      <= cfg_wdata;
        tts_pkg::REG_SMOOTHING:   cfg.smoothing        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tts_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### sim/testbench.sv
// Self-checking testbench for tilt_to_stick_shaper: drives accelerometer samples and
// calibrate events over the stream ports, predicts aileron/elevator per transaction.
// Depends on tts_pkg and the RTL under rtl/core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        act;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } sample_t;

  typedef struct packed {
    logic [15:0] ail;
    logic [15:0] elev;
    logic        upd;
  } stick_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0, s_tready, s_tuser;
  logic [47:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0, m_tuser;
  logic [31:0] m_tdata;
  logic cfg_wen = 0;
  logic [2:0] cfg_index = '0;
  logic [14:0] cfg_wdata = '0;
  logic s_sel = 0;

  assign s_tuser = s_sel;

  tilt_to_stick_shaper dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_wen, .cfg_index, .cfg_wdata
  );

  // predictor state
  logic        en_r;
  logic [14:0] pfull_r, rfull_r, ew_r, sm_r;
  logic [13:0] dz_r;
  longint      refp, refr, ail_f, elev_f;
  bit          have_ref;

  sample_t pending_q[$];
  stick_t  stick_q[$];
  int      send_idle = 0, recv_stall = 0, hold_off = 0;
  int      errors = 0, n_out = 0, n_upd = 0, n_cal = 0;
  longint  cycles = 0;

  initial forever #1 clk = ~clk;

  function automatic longint shr_r(longint v, int sh);
    if (v >= 0) return v >>> sh;
    return -1 - ((-1 - v) >>> sh);
  endfunction

  function automatic longint angle_of(longint num, longint den);
    longint xv, yv, acc, dx, dy;
    longint tab[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                        131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
    acc = 0;
    if (num == 0 && den == 0) return 0;
    if (den < 0) begin
      acc = (num >= 0) ? 52707179 : -52707179;
      den = -den;
      num = -num;
    end
    xv = den * 16384;
    yv = num * 16384;
    for (int i = 0; i < 16; i++) begin
      dx = shr_r(yv, i);
      dy = shr_r(xv, i);
      if (yv > 0) begin
        xv += dx; yv -= dy; acc += tab[i];
      end else begin
        xv -= dx; yv += dy; acc -= tab[i];
      end
    end
    acc = shr_r(acc + 1024, 11);
    if (acc > 25736) acc = 25736;
    if (acc < -25736) acc = -25736;
    return acc;
  endfunction

  function automatic longint root_of(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint deflection(longint d, longint full);
    longint m, q;
    m = d < 0 ? -d : d;
    if (full == 0) full = 1;
    q = ((m << 14) + full / 2) / full;
    if (q > 16384) q = 16384;
    return d < 0 ? -q : q;
  endfunction

  function automatic longint shaped(longint v);
    longint m, dz, wt, den, lin, cub, res;
    m = v < 0 ? -v : v;
    dz = dz_r;
    wt = ew_r > 16384 ? 16384 : ew_r;
    if (dz >= 16384 || m < dz) return 0;
    den = 16384 - dz;
    lin = (((m - dz) << 14) + den / 2) / den;
    if (lin > 16384) lin = 16384;
    cub = (lin * lin * lin + (64'd1 << 27)) >> 28;
    res = (wt * cub + (16384 - wt) * lin + 8192) >> 14;
    return v < 0 ? -res : res;
  endfunction

  function automatic longint smoothed(longint old, longint v);
    longint a, acc;
    a = sm_r > 16384 ? 16384 : sm_r;
    acc = old * (16384 - a) + v * 4 * a;
    acc = shr_r(acc + 8192, 14);
    if (acc > 65536) acc = 65536;
    if (acc < -65536) acc = -65536;
    return acc;
  endfunction

  function automatic logic [15:0] q14_of(longint f);
    longint r;
    r = shr_r(f + 2, 2);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  task automatic predict_stick(sample_t s);
    longint ax, ay, az, pa, ra;
    stick_t e;
    ax = $signed(s.x);
    ay = $signed(s.y);
    az = $signed(s.z);
    pa = angle_of(ax, az);
    ra = angle_of(ay, root_of(ax * ax + az * az));
    e.upd = 0;
    if (s.act || (en_r && !have_ref)) begin
      refp = pa; refr = ra; have_ref = 1; n_cal++;
    end else if (!en_r) begin
      ail_f = 0; elev_f = 0;
    end else begin
      ail_f = smoothed(ail_f, shaped(deflection(ra - refr, rfull_r)));
      elev_f = smoothed(elev_f, shaped(-deflection(pa - refp, pfull_r)));
      e.upd = 1;
    end
    e.ail = q14_of(ail_f);
    e.elev = q14_of(elev_f);
    stick_q.push_back(e);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("timeout at %0t", $time);
      $display("** tilt_to_stick_shaper: FAILED **");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_stick({s_sel, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]});
      if ((!s_tvalid || s_tready) && pending_q.size() > 0 &&
          $urandom_range(99) >= send_idle) begin
        sample_t s;
        s = pending_q.pop_front();
        s_tvalid <= 1;
        s_sel <= s.act;
        s_tdata <= {s.z, s.y, s.x};
      end else if (s_tvalid && s_tready) s_tvalid <= 0;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        stick_t g, e;
        g = {m_tdata[15:0], m_tdata[31:16], m_tuser};
        n_out++;
        if (g.upd) n_upd++;
        if (stick_q.size() == 0) begin
          $display("%0t unexpected result %h", $time, g);
          errors++;
        end else begin
          e = stick_q.pop_front();
          if (g.ail !== e.ail)
            $display("%0t aileron exp %0d got %0d", $time, $signed(e.ail), $signed(g.ail));
          if (g.elev !== e.elev)
            $display("%0t elevator exp %0d got %0d", $time, $signed(e.elev),
                     $signed(g.elev));
          if (g.upd !== e.upd)
            $display("%0t updated exp %0d got %0d", $time, e.upd, g.upd);
          if (g !== e) errors++;
        end
      end
      if (hold_off > 0) m_tready <= 0;
      else m_tready <= $urandom_range(99) >= recv_stall;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    @(posedge clk);
    cfg_wen <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 0;
    case (idx)
      tts_pkg::REG_TILT_ENABLE: en_r = val[0];
      tts_pkg::REG_PITCH_FULL:  pfull_r = val;
      tts_pkg::REG_ROLL_FULL:   rfull_r = val;
      tts_pkg::REG_DEAD_ZONE:   dz_r = val[13:0];
      tts_pkg::REG_EXPO_WEIGHT: ew_r = val;
      tts_pkg::REG_SMOOTHING:   sm_r = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_q.size() > 0 || s_tvalid || stick_q.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic [15:0] axis_val();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 400) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      sample_t s;
      s.act = $urandom_range(19) == 0;
      s.x = axis_val();
      s.y = axis_val();
      s.z = axis_val();
      pending_q.push_back(s);
    end
  endtask

  initial begin
    en_r = 1; pfull_r = tts_pkg::RST_PITCH_FULL; rfull_r = tts_pkg::RST_ROLL_FULL;
    dz_r = tts_pkg::RST_DEAD_ZONE; ew_r = tts_pkg::RST_EXPO_WEIGHT;
    sm_r = tts_pkg::RST_SMOOTHING;
    refp = 0; refr = 0; have_ref = 0; ail_f = 0; elev_f = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    // directed: first sample calibrates, zero vector, extremes, calibrate, disable
    pending_q.push_back('{0, 16'd0, 16'd0, 16'd0});
    pending_q.push_back('{0, 16'd0, 16'd0, 16'd0});
    pending_q.push_back('{0, 16'h8000, 16'h8000, 16'h8000});
    pending_q.push_back('{0, 16'h7fff, 16'h7fff, 16'h7fff});
    pending_q.push_back('{0, 16'h7fff, 16'h8000, 16'hffff});
    pending_q.push_back('{0, 16'h8000, 16'h7fff, 16'h0000});
    pending_q.push_back('{1, 16'd100, 16'd0, 16'd4000});
    pending_q.push_back('{0, 16'd1500, 16'hfa00, 16'd4000});
    pending_q.push_back('{0, 16'hfa00, 16'd1500, 16'hf000});
    pending_q.push_back('{0, 16'd0, 16'd0, 16'h8000});
    drain();
    write_reg(tts_pkg::REG_TILT_ENABLE, 0);
    pending_q.push_back('{0, 16'd300, 16'd300, 16'd4000});
    pending_q.push_back('{1, 16'd0, 16'd0, 16'd4000});
    drain();
    write_reg(tts_pkg::REG_TILT_ENABLE, 1);
    write_reg(tts_pkg::REG_PITCH_FULL, 0);
    write_reg(tts_pkg::REG_ROLL_FULL, 15'h7fff);
    write_reg(tts_pkg::REG_DEAD_ZONE, 14'h3fff);
    write_reg(tts_pkg::REG_EXPO_WEIGHT, 15'h7fff);
    write_reg(tts_pkg::REG_SMOOTHING, 15'h7fff);
    queue_random(8);
    drain();
    write_reg(tts_pkg::REG_DEAD_ZONE, 0);
    write_reg(tts_pkg::REG_SMOOTHING, 0);
    write_reg(tts_pkg::REG_EXPO_WEIGHT, 0);
    queue_random(5);
    drain();
    // random phases with varied settings and idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 71; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 71; end
        default: begin send_idle = 17; recv_stall = 17; end
      endcase
      write_reg(tts_pkg::REG_TILT_ENABLE, $urandom_range(9) != 0);
      write_reg(tts_pkg::REG_PITCH_FULL,
                ph == 5 ? 15'd25736 : 15'($urandom_range(1, 25736)));
      write_reg(tts_pkg::REG_ROLL_FULL, ph == 6 ? 15'd1 : 15'($urandom_range(1, 25736)));
      write_reg(tts_pkg::REG_DEAD_ZONE, 14'($urandom_range(0, 3000)));
      write_reg(tts_pkg::REG_EXPO_WEIGHT, 15'($urandom_range(0, 16384)));
      write_reg(tts_pkg::REG_SMOOTHING, 15'($urandom_range(0, 16384)));
      if (ph == 2) hold_off = 3000;
      queue_random(128);
      drain();
    end
    $display("covered %0d transactions, %0d filter updates, %0d reference captures",
             n_out, n_upd, n_cal);
    if (errors == 0) $display("** tilt_to_stick_shaper: PASSED **");
    else $display("** tilt_to_stick_shaper: FAILED **");
    $finish;
  end
endmodule
